// ----- hw/rtl/rccd_pkg.sv -----
package rccd_pkg;

  localparam logic [7:0] TRAILER_OK   = 8'h8B;
  localparam logic [7:0] KEY_LEFT     = 8'hE1;
  localparam logic [7:0] KEY_RIGHT    = 8'hC8;
  localparam logic signed [9:0] STICK_OFFSET = 10'sd50;

  localparam logic [15:0] THROTTLE_MAX_RST   = 16'd1000;
  localparam logic [6:0]  DEAD_BAND_RST      = 7'd5;
  localparam logic [7:0]  LOSS_LIMIT_RST     = 8'd200;
  localparam logic [9:0]  THROTTLE_FLOOR_RST = 10'd10;
  localparam logic [15:0] HOLD_COUNT_RST     = 16'd50000;
  localparam logic [7:0]  TILT_LIMIT_RST     = 8'd35;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THROTTLE_MAX   = 3'd0,
    REG_DEAD_BAND      = 3'd1,
    REG_LOSS_LIMIT     = 3'd2,
    REG_THROTTLE_FLOOR = 3'd3,
    REG_HOLD_COUNT     = 3'd4,
    REG_TILT_LIMIT     = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_LEFT  = 2'd1,
    MODE_RIGHT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    LED_NONE     = 2'd0,
    LED_ENABLED  = 2'd1,
    LED_DISABLED = 2'd2
  } led_t;

  localparam int CLR_ALT_MARK = 0;
  localparam int CLR_FLOW     = 1;
  localparam int CLR_POS_MARK = 2;

  // result word, lowest field last
  typedef struct packed {
    logic              pad;
    logic [2:0]        clear_pulses;
    led_t              position_led;
    led_t              altitude_led;
    logic              position_hold;
    logic              altitude_hold;
    mode_t             mode;
    logic              signal_lost;
    logic signed [8:0] yaw;
    logic signed [8:0] roll;
    logic signed [8:0] pitch;
    logic [15:0]       throttle;
  } res_t;

  localparam int RES_W = $bits(res_t);

  function automatic logic signed [8:0] dead_zone(input logic signed [9:0] v,
                                                  input logic [6:0] d);
    logic signed [9:0] dp;
    dp = signed'({3'b000, d});
    if (v >= -dp && v <= dp) begin
      return 9'sd0;
    end
    return v[8:0];
  endfunction

endpackage

// ----- hw/rtl/rc_command_decoder_failsafe.sv -----
// An accepted poll's result is registered in the result register, or in the skid entry.
// Throughput: one poll per cycle while s_axis_tready is high; all decode, failsafe and
// key-hold logic sits between the stored state and the result register.
// Output side holds a result register and one skid entry, so s_axis_tready only
// drops while both are full.
// Reset (rst, synchronous): state cleared, registers back to defaults, no result held.
module rc_command_decoder_failsafe
  import rccd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // throttle_low, throttle_high, pitch_raw, roll_raw, yaw_raw, left_key, right_key, trailer
  input  logic [63:0]           s_axis_tdata,
  // received
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // throttle, pitch, roll, yaw, signal_lost, mode, altitude_hold, position_hold,
  // altitude_led, position_led, clear_pulses, zero pad
  output logic [RES_W-1:0]      m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0] throttle_max;
  logic [6:0]  dead_band;
  logic [7:0]  loss_limit;
  logic [9:0]  throttle_floor;
  logic [15:0] hold_count;
  logic [7:0]  tilt_limit;

  logic [15:0]       throttle_reg, throttle_next;
  logic signed [8:0] pitch_reg, pitch_next;
  logic signed [8:0] roll_reg, roll_next;
  logic signed [8:0] yaw_reg, yaw_next;
  logic [7:0]        left_key_reg, left_key_next;
  logic [7:0]        right_key_reg, right_key_next;
  logic [7:0]        loss_counter, loss_counter_next;
  logic              lost_flag, lost_flag_next;
  mode_t             mode_reg, mode_next;
  logic              alt_hold_flag, alt_hold_next;
  logic              pos_hold_flag, pos_hold_next;
  logic [15:0]       alt_hold_counter, alt_hold_counter_next;
  logic [15:0]       pos_hold_counter, pos_hold_counter_next;
  led_t              alt_led_code, alt_led_next;
  led_t              pos_led_code, pos_led_next;
  logic [2:0]        clears;

  logic              out_valid, skid_valid;
  res_t              out_data, skid_data, res;
  logic              in_fire, out_take;

  assign s_axis_tready = !skid_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_take      = out_valid && m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_max   <= THROTTLE_MAX_RST;
      dead_band      <= DEAD_BAND_RST;
      loss_limit     <= LOSS_LIMIT_RST;
      throttle_floor <= THROTTLE_FLOOR_RST;
      hold_count     <= HOLD_COUNT_RST;
      tilt_limit     <= TILT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THROTTLE_MAX:   throttle_max   <= cfg_data;
        REG_DEAD_BAND:      dead_band      <= cfg_data[6:0];
        REG_LOSS_LIMIT:     loss_limit     <= cfg_data[7:0];
        REG_THROTTLE_FLOOR: throttle_floor <= cfg_data[9:0];
        REG_HOLD_COUNT:     hold_count     <= cfg_data;
        REG_TILT_LIMIT:     tilt_limit     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [7:0]        b_thr_lo, b_thr_hi, b_pitch, b_roll, b_yaw, b_lkey, b_rkey, b_trailer;
  logic [15:0]       thr_raw, thr_tmp;
  logic [7:0]        lc_tmp;
  logic signed [9:0] tl, tl_neg;
  logic              alt_qual, pos_qual;
  logic [15:0]       alt_inc, pos_inc;

  assign {b_trailer, b_rkey, b_lkey, b_yaw, b_roll, b_pitch, b_thr_hi, b_thr_lo} =
    s_axis_tdata;
  assign thr_raw = {b_thr_hi, b_thr_lo};
  assign tl      = signed'({2'b00, tilt_limit});
  assign tl_neg  = -tl;

  always_comb begin
    throttle_next         = throttle_reg;
    pitch_next            = pitch_reg;
    roll_next             = roll_reg;
    yaw_next              = yaw_reg;
    left_key_next         = left_key_reg;
    right_key_next        = right_key_reg;
    loss_counter_next     = loss_counter;
    lost_flag_next        = lost_flag;
    mode_next             = mode_reg;
    alt_hold_next         = alt_hold_flag;
    pos_hold_next         = pos_hold_flag;
    alt_hold_counter_next = alt_hold_counter;
    pos_hold_counter_next = pos_hold_counter;
    alt_led_next          = alt_led_code;
    pos_led_next          = pos_led_code;
    clears                = 3'b000;
    thr_tmp               = throttle_reg;
    lc_tmp                = loss_counter;
    alt_qual              = 1'b0;
    pos_qual              = 1'b0;
    alt_inc               = alt_hold_counter;
    pos_inc               = pos_hold_counter;

    if (s_axis_tuser[0]) begin
      if (b_trailer == TRAILER_OK) begin
        loss_counter_next = '0;
        throttle_next  = (thr_raw > throttle_max) ? throttle_max : thr_raw;
        pitch_next     = dead_zone(STICK_OFFSET - signed'({{2{b_pitch[7]}}, b_pitch}),
                                   dead_band);
        roll_next      = dead_zone(STICK_OFFSET - signed'({{2{b_roll[7]}}, b_roll}),
                                   dead_band);
        yaw_next       = dead_zone(signed'({{2{b_yaw[7]}}, b_yaw}) - STICK_OFFSET,
                                   dead_band);
        left_key_next  = b_lkey;
        right_key_next = b_rkey;
      end
    end else begin
      if (loss_counter < loss_limit) begin
        lc_tmp         = loss_counter + 8'd1;
        lost_flag_next = 1'b0;
      end
      if (lc_tmp == loss_limit) begin
        lost_flag_next = 1'b1;
        if (thr_tmp > {6'd0, throttle_floor}) begin
          thr_tmp = thr_tmp - 16'd1;
        end
      end
      if (thr_tmp > throttle_max) begin
        thr_tmp = throttle_max;
      end
      loss_counter_next = lc_tmp;
      throttle_next     = thr_tmp;
    end

    // key-hold step on the updated values
    if (left_key_next == KEY_LEFT) begin
      mode_next = MODE_LEFT;
      alt_qual  = (signed'({pitch_next[8], pitch_next}) <= tl) &&
                  (signed'({roll_next[8], roll_next}) >= tl_neg);
      if (alt_qual) begin
        if (alt_hold_counter < hold_count) begin
          alt_inc = alt_hold_counter + 16'd1;
        end
        alt_hold_counter_next = alt_inc;
        if (alt_inc >= hold_count) begin
          alt_hold_counter_next = '0;
          if (!alt_hold_flag) begin
            alt_hold_next = 1'b1;
            alt_led_next  = LED_ENABLED;
          end else begin
            alt_hold_next = 1'b0;
            alt_led_next  = LED_DISABLED;
            clears[CLR_ALT_MARK] = 1'b1;
          end
        end
      end
    end
    if (right_key_next == KEY_RIGHT) begin
      mode_next = MODE_RIGHT;
      pos_qual  = (signed'({yaw_next[8], yaw_next}) >= tl_neg);
      if (pos_qual) begin
        if (pos_hold_counter < hold_count) begin
          pos_inc = pos_hold_counter + 16'd1;
        end
        pos_hold_counter_next = pos_inc;
        if (pos_inc >= hold_count) begin
          pos_hold_counter_next = '0;
          if (!pos_hold_flag) begin
            pos_hold_next = 1'b1;
            pos_led_next  = LED_ENABLED;
            clears[CLR_FLOW] = 1'b1;
          end else begin
            pos_hold_next = 1'b0;
            pos_led_next  = LED_DISABLED;
            clears[CLR_POS_MARK] = 1'b1;
          end
        end
      end
    end
    if (left_key_next != KEY_LEFT && right_key_next != KEY_RIGHT) begin
      mode_next = MODE_NONE;
    end
  end

  always_comb begin
    res               = '0;
    res.throttle      = throttle_next;
    res.pitch         = pitch_next;
    res.roll          = roll_next;
    res.yaw           = yaw_next;
    res.signal_lost   = lost_flag_next;
    res.mode          = mode_next;
    res.altitude_hold = alt_hold_next;
    res.position_hold = pos_hold_next;
    res.altitude_led  = alt_led_next;
    res.position_led  = pos_led_next;
    res.clear_pulses  = clears;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_reg     <= '0;
      pitch_reg        <= '0;
      roll_reg         <= '0;
      yaw_reg          <= '0;
      left_key_reg     <= '0;
      right_key_reg    <= '0;
      loss_counter     <= '0;
      lost_flag        <= 1'b0;
      mode_reg         <= MODE_NONE;
      alt_hold_flag    <= 1'b0;
      pos_hold_flag    <= 1'b0;
      alt_hold_counter <= '0;
      pos_hold_counter <= '0;
      alt_led_code     <= LED_NONE;
      pos_led_code     <= LED_NONE;
    end else if (in_fire) begin
      throttle_reg     <= throttle_next;
      pitch_reg        <= pitch_next;
      roll_reg         <= roll_next;
      yaw_reg          <= yaw_next;
      left_key_reg     <= left_key_next;
      right_key_reg    <= right_key_next;
      loss_counter     <= loss_counter_next;
      lost_flag        <= lost_flag_next;
      mode_reg         <= mode_next;
      alt_hold_flag    <= alt_hold_next;
      pos_hold_flag    <= pos_hold_next;
      alt_hold_counter <= alt_hold_counter_next;
      pos_hold_counter <= pos_hold_counter_next;
      alt_led_code     <= alt_led_next;
      pos_led_code     <= pos_led_next;
    end
  end

  // result register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_valid || out_take) begin
        out_data <= res;
      end else begin
        skid_data <= res;
      end
    end else if (out_take && skid_valid) begin
      out_data <= skid_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty result register");

  a_loss_only_on_poll: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(in_fire)) |-> ($stable(loss_counter) && $stable(throttle_reg)))
    else $error("poll state changed without a transaction");

  a_lost_needs_tick: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(lost_flag)) |-> $past(in_fire && !s_axis_tuser[0]))
    else $error("signal lost raised without a missed poll");

  a_alt_toggle_pulse: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(alt_hold_flag)) |-> $past(clears[CLR_ALT_MARK]))
    else $error("altitude hold cleared without mark clear pulse");

endmodule

// ----- dv/tb_rc_command_decoder_failsafe.sv -----
module tb_rc_command_decoder_failsafe;
  timeunit 1ns;
  timeprecision 1ps;
  import rccd_pkg::*;

  typedef enum logic [1:0] {
    PLAN_TICK,
    PLAN_PKT,
    PLAN_WRITE
  } plan_op_t;

  typedef struct {
    plan_op_t    op;
    cfg_reg_t    idx;
    logic [63:0] word;
    bit          known;
    res_t        want;
  } plan_row_t;

  localparam res_t EXP_IDLE = '{pad: 1'b0, clear_pulses: 3'd0,
                                position_led: LED_NONE, altitude_led: LED_NONE,
                                position_hold: 1'b0, altitude_hold: 1'b0,
                                mode: MODE_NONE, signal_lost: 1'b0,
                                yaw: 9'sd0, roll: 9'sd0, pitch: 9'sd0, throttle: 16'd0};
  localparam res_t EXP_TOP = '{pad: 1'b0, clear_pulses: 3'd0,
                               position_led: LED_NONE, altitude_led: LED_NONE,
                               position_hold: 1'b0, altitude_hold: 1'b0,
                               mode: MODE_NONE, signal_lost: 1'b0,
                               yaw: -9'sd178, roll: -9'sd77, pitch: 9'sd178,
                               throttle: 16'd1000};
  localparam res_t EXP_BOTTOM = '{pad: 1'b0, clear_pulses: 3'd0,
                                  position_led: LED_NONE, altitude_led: LED_NONE,
                                  position_hold: 1'b0, altitude_hold: 1'b0,
                                  mode: MODE_NONE, signal_lost: 1'b0,
                                  yaw: 9'sd77, roll: 9'sd178, pitch: -9'sd77,
                                  throttle: 16'd1000};

  localparam int PLAN_LEN = 37;

  // directed polls and register writes, walked in order
  plan_row_t plan [PLAN_LEN] = '{
    '{PLAN_TICK,  REG_THROTTLE_MAX,   64'h8B00_0080_7F80_FFFF, 1'b1, EXP_IDLE},
    '{PLAN_PKT,   REG_THROTTLE_MAX,   64'h8AC8_E180_7F80_FFFF, 1'b1, EXP_IDLE},
    '{PLAN_PKT,   REG_THROTTLE_MAX,   64'h8B00_0080_7F80_FFFF, 1'b1, EXP_TOP},
    '{PLAN_PKT,   REG_THROTTLE_MAX,   64'h8B00_007F_807F_03E9, 1'b1, EXP_BOTTOM},
    '{PLAN_PKT,   REG_THROTTLE_MAX,   64'h8B00_0037_372D_0000, 1'b1, EXP_IDLE},
    '{PLAN_PKT,   REG_THROTTLE_MAX,   64'h8BC8_E12C_382C_03E8, 1'b0, EXP_IDLE},
    '{PLAN_PKT,   REG_THROTTLE_MAX,   64'h0000_0011_2233_4455, 1'b0, EXP_IDLE},
    '{PLAN_WRITE, REG_HOLD_COUNT,     64'd3,                   1'b0, EXP_IDLE},
    '{PLAN_WRITE, REG_TILT_LIMIT,     64'd178,                 1'b0, EXP_IDLE},
    '{PLAN_WRITE, REG_LOSS_LIMIT,     64'd3,                   1'b0, EXP_IDLE},
    '{PLAN_WRITE, REG_THROTTLE_FLOOR, 64'd995,                 1'b0, EXP_IDLE},
    '{PLAN_WRITE, REG_THROTTLE_MAX,   64'd65535,               1'b0, EXP_IDLE},
    '{PLAN_WRITE, REG_DEAD_BAND,      64'd0,                   1'b0, EXP_IDLE},
    '{PLAN_PKT,   REG_THROTTLE_MAX,   64'h8BC8_E132_3232_03E8, 1'b0, EXP_IDLE},
    '{PLAN_TICK,  REG_THROTTLE_MAX,   64'h0000_0000_0000_0000, 1'b0, EXP_IDLE},
    '{PLAN_TICK,  REG_THROTTLE_MAX,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, EXP_IDLE},
    '{PLAN_TICK,  REG_THROTTLE_MAX,   64'h5A5A_5A5A_5A5A_5A5A, 1'b0, EXP_IDLE},
    '{PLAN_TICK,  REG_THROTTLE_MAX,   64'hA5A5_A5A5_A5A5_A5A5, 1'b0, EXP_IDLE},
    '{PLAN_TICK,  REG_THROTTLE_MAX,   64'h8BC8_E132_3232_03E8, 1'b0, EXP_IDLE},
    // recovery: lost flag must survive this packet
    '{PLAN_PKT,   REG_THROTTLE_MAX,   64'h8B00_0032_3232_0FFF, 1'b0, EXP_IDLE},
    '{PLAN_TICK,  REG_THROTTLE_MAX,   64'h0,                   1'b0, EXP_IDLE},
    '{PLAN_TICK,  REG_THROTTLE_MAX,   64'h0,                   1'b0, EXP_IDLE},
    '{PLAN_TICK,  REG_THROTTLE_MAX,   64'h0,                   1'b0, EXP_IDLE},
    // limit dropped under the running counter
    '{PLAN_WRITE, REG_THROTTLE_MAX,   64'd500,                 1'b0, EXP_IDLE},
    '{PLAN_WRITE, REG_LOSS_LIMIT,     64'd1,                   1'b0, EXP_IDLE},
    '{PLAN_TICK,  REG_THROTTLE_MAX,   64'h0,                   1'b0, EXP_IDLE},
    '{PLAN_WRITE, REG_HOLD_COUNT,     64'd0,                   1'b0, EXP_IDLE},
    '{PLAN_PKT,   REG_THROTTLE_MAX,   64'h8BC8_E132_3232_0100, 1'b0, EXP_IDLE},
    '{PLAN_PKT,   REG_THROTTLE_MAX,   64'h8BC8_E180_7F80_0100, 1'b0, EXP_IDLE},
    '{PLAN_WRITE, REG_TILT_LIMIT,     64'd0,                   1'b0, EXP_IDLE},
    '{PLAN_WRITE, REG_HOLD_COUNT,     64'd65535,               1'b0, EXP_IDLE},
    '{PLAN_PKT,   REG_THROTTLE_MAX,   64'h8BC8_E12C_322C_0100, 1'b0, EXP_IDLE},
    '{PLAN_PKT,   REG_THROTTLE_MAX,   64'h8B00_0032_3232_0100, 1'b0, EXP_IDLE},
    '{PLAN_WRITE, REG_LOSS_LIMIT,     64'd0,                   1'b0, EXP_IDLE},
    '{PLAN_WRITE, REG_THROTTLE_FLOOR, 64'd0,                   1'b0, EXP_IDLE},
    '{PLAN_TICK,  REG_THROTTLE_MAX,   64'h0,                   1'b0, EXP_IDLE},
    '{PLAN_TICK,  REG_THROTTLE_MAX,   64'h0,                   1'b0, EXP_IDLE}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [RES_W-1:0]      m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_THROTTLE_MAX;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor configuration
  logic [15:0] lim_thr_max = THROTTLE_MAX_RST;
  logic [6:0]  lim_band    = DEAD_BAND_RST;
  logic [7:0]  lim_loss    = LOSS_LIMIT_RST;
  logic [9:0]  lim_floor   = THROTTLE_FLOOR_RST;
  logic [15:0] lim_hold    = HOLD_COUNT_RST;
  logic [7:0]  lim_tilt    = TILT_LIMIT_RST;

  // predictor state
  int          cmd_thr = 0, cmd_pitch = 0, cmd_roll = 0, cmd_yaw = 0;
  logic [7:0]  key_l = '0, key_r = '0;
  int          miss_cnt = 0;
  bit          lost = 1'b0;
  mode_t       cur_mode = MODE_NONE;
  bit          alt_on = 1'b0, pos_on = 1'b0;
  int          alt_cnt = 0, pos_cnt = 0;
  led_t        alt_led = LED_NONE, pos_led = LED_NONE;

  res_t cmd_due [$];
  int   n_errors = 0;
  int   n_results = 0;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;

  rc_command_decoder_failsafe dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int in_band(input int v);
    int d;
    d = int'(lim_band);
    return (v >= -d && v <= d) ? 0 : v;
  endfunction

  function automatic bit hold_step(inout int cnt);
    if (cnt < int'(lim_hold)) cnt = (cnt + 1) & 16'hFFFF;
    if (cnt >= int'(lim_hold)) begin
      cnt = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic res_t decode_poll(input logic recv, input logic [63:0] w);
    res_t r;
    int   req_thr;
    int   tl;
    r = EXP_IDLE;
    if (recv) begin
      if (w[63:56] == TRAILER_OK) begin
        req_thr = int'(w[15:0]);
        miss_cnt = 0;
        cmd_thr = (req_thr > int'(lim_thr_max)) ? int'(lim_thr_max) : req_thr;
        cmd_pitch = in_band(int'(STICK_OFFSET) - int'($signed(w[23:16])));
        cmd_roll = in_band(int'(STICK_OFFSET) - int'($signed(w[31:24])));
        cmd_yaw = in_band(int'($signed(w[39:32])) - int'(STICK_OFFSET));
        key_l = w[47:40];
        key_r = w[55:48];
      end
    end else begin
      if (miss_cnt < int'(lim_loss)) begin
        miss_cnt++;
        lost = 1'b0;
      end
      if (miss_cnt == int'(lim_loss)) begin
        lost = 1'b1;
        if (cmd_thr > int'(lim_floor)) cmd_thr--;
      end
      if (cmd_thr > int'(lim_thr_max)) cmd_thr = int'(lim_thr_max);
    end

    tl = int'(lim_tilt);
    if (key_l == KEY_LEFT) begin
      cur_mode = MODE_LEFT;
      if (cmd_pitch <= tl && cmd_roll >= -tl) begin
        if (hold_step(alt_cnt)) begin
          alt_on = !alt_on;
          alt_led = alt_on ? LED_ENABLED : LED_DISABLED;
          if (!alt_on) r.clear_pulses[CLR_ALT_MARK] = 1'b1;
        end
      end
    end
    if (key_r == KEY_RIGHT) begin
      cur_mode = MODE_RIGHT;
      if (cmd_yaw >= -tl) begin
        if (hold_step(pos_cnt)) begin
          pos_on = !pos_on;
          pos_led = pos_on ? LED_ENABLED : LED_DISABLED;
          if (pos_on) r.clear_pulses[CLR_FLOW] = 1'b1;
          else r.clear_pulses[CLR_POS_MARK] = 1'b1;
        end
      end
    end
    if (key_l != KEY_LEFT && key_r != KEY_RIGHT) cur_mode = MODE_NONE;

    r.throttle = cmd_thr[15:0];
    r.pitch = cmd_pitch[8:0];
    r.roll = cmd_roll[8:0];
    r.yaw = cmd_yaw[8:0];
    r.signal_lost = lost;
    r.mode = cur_mode;
    r.altitude_hold = alt_on;
    r.position_hold = pos_on;
    r.altitude_led = alt_led;
    r.position_led = pos_led;
    return r;
  endfunction

  function automatic string show(input res_t r);
    return $sformatf("thr=%0d pitch=%0d roll=%0d yaw=%0d lost=%b mode=%0d %s",
                     r.throttle, r.pitch, r.roll, r.yaw, r.signal_lost, r.mode,
                     $sformatf("alt=%b/%0d pos=%b/%0d clr=%b pad=%b", r.altitude_hold,
                               r.altitude_led, r.position_hold, r.position_led,
                               r.clear_pulses, r.pad));
  endfunction

  function automatic bit fields_match(input res_t a, input res_t b);
    return a.throttle === b.throttle && a.pitch === b.pitch && a.roll === b.roll &&
           a.yaw === b.yaw && a.signal_lost === b.signal_lost && a.mode === b.mode &&
           a.altitude_hold === b.altitude_hold && a.position_hold === b.position_hold &&
           a.altitude_led === b.altitude_led && a.position_led === b.position_led &&
           a.clear_pulses === b.clear_pulses && a.pad === b.pad;
  endfunction

  function automatic void note_failure(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("MISMATCH %s", msg);
  endfunction

  function automatic logic [15:0] pick(input int ph, input int lo, input int hi,
                                       input int a, input int b);
    int r;
    r = $urandom_range(0, 9);
    if (ph == 0 || (ph > 1 && r == 0)) return 16'(lo);
    if (ph == 1 || (ph > 1 && r == 1)) return 16'(hi);
    return 16'($urandom_range(b, a));
  endfunction

  function automatic logic [7:0] rand_stick();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'(int'(STICK_OFFSET) + $urandom_range(0, 40) - 20);
  endfunction

  function automatic logic [7:0] rand_key(input logic [7:0] code);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return code;
    if (r == 5) return 8'($urandom_range(0, 255));
    return 8'h00;
  endfunction

  function automatic logic [63:0] rand_packet(input bit good);
    logic [15:0] thr;
    logic [7:0]  trl;
    thr = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                      : 16'($urandom_range(0, 1200));
    trl = TRAILER_OK;
    if (!good) begin
      trl = 8'($urandom_range(0, 255));
      if (trl == TRAILER_OK) trl ^= 8'(1 << $urandom_range(0, 7));
    end
    return {trl, rand_key(KEY_RIGHT), rand_key(KEY_LEFT), rand_stick(), rand_stick(),
            rand_stick(), thr};
  endfunction

  // all tasks start and end just after a rising edge
  task automatic send_poll(input logic recv, input logic [63:0] w, input bit known,
                           input res_t want);
    res_t pred;
    if (cfg_we) cfg_we <= 1'b0;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= recv;
    s_axis_tdata <= w;
    do @(posedge clk); while (!s_axis_tready);
    pred = decode_poll(recv, w);
    cmd_due.push_back(known ? want : pred);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (cmd_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_THROTTLE_MAX:   lim_thr_max = val;
      REG_DEAD_BAND:      lim_band = val[6:0];
      REG_LOSS_LIMIT:     lim_loss = val[7:0];
      REG_THROTTLE_FLOOR: lim_floor = val[9:0];
      REG_HOLD_COUNT:     lim_hold = val;
      REG_TILT_LIMIT:     lim_tilt = val[7:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (cmd_due.size() == 0) begin
        note_failure($sformatf("result %0d with nothing pending: %s", n_results, show(got)));
      end else begin
        want = cmd_due.pop_front();
        if (!fields_match(got, want))
          note_failure($sformatf("result %0d\n  expected %s\n  actual   %s",
                                 n_results, show(want), show(got)));
      end
      n_results++;
    end
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    bit writing;
    int tick_left;
    int burst_max;
    writing = 1'b0;
    tick_left = 0;
    src_idle_pct = 36;
    sink_stall_pct = 36;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].op == PLAN_WRITE) begin
        if (!writing) drain();
        writing = 1'b1;
        write_reg(plan[i].idx, plan[i].word[CFG_DATA_W-1:0]);
      end else begin
        writing = 1'b0;
        send_poll(plan[i].op == PLAN_PKT, plan[i].word, plan[i].known, plan[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 85; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 85; end
        default: begin src_idle_pct = 36; sink_stall_pct = 36; end
      endcase
      write_reg(REG_THROTTLE_MAX, pick(ph, 0, 65535, 200, 2000));
      write_reg(REG_DEAD_BAND, pick(ph, 0, 127, 0, 20));
      write_reg(REG_LOSS_LIMIT, pick(ph, 1, 255, 1, 12));
      write_reg(REG_THROTTLE_FLOOR, pick(ph, 0, 1000, 0, 900));
      write_reg(REG_HOLD_COUNT, pick(ph, 1, 65535, 1, 6));
      write_reg(REG_TILT_LIMIT, pick(ph, 0, 178, 10, 120));
      burst_max = (int'(lim_loss) + 4 > 40) ? 40 : int'(lim_loss) + 4;
      tick_left = 0;
      for (int k = 0; k < 80; k++) begin
        if (ph == 2 && k == 40) drain();
        if (tick_left == 0 && $urandom_range(0, 5) == 0)
          tick_left = $urandom_range(1, burst_max);
        if (tick_left != 0) begin
          tick_left--;
          send_poll(1'b0, {$urandom, $urandom}, 1'b0, EXP_IDLE);
        end else begin
          send_poll(1'b1, rand_packet($urandom_range(0, 9) != 0), 1'b0, EXP_IDLE);
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- rc_command_decoder_failsafe.f -----
hw/rtl/rccd_pkg.sv
hw/rtl/rc_command_decoder_failsafe.sv
dv/tb_rc_command_decoder_failsafe.sv
